/* rtl/ecal_pkg.sv */
// Shared types and constants for the epoch seconds to calendar converter.
// Used by ecal_alu and epoch_seconds_to_calendar_core; no dependencies.
package ecal_pkg;

    localparam int ALU_W = 32;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [11:0] FIRST_YEAR    = 12'd1970;

    // Residues of the first year, so the leap test needs no division.
    localparam logic [1:0] FIRST_MOD4   = 2'd2;
    localparam logic [6:0] FIRST_MOD100 = 7'd70;
    localparam logic [8:0] FIRST_MOD400 = 9'd370;

    localparam logic [3:0] LAST_MONTH = 4'd11;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_DAYS  = 8'b0000_0100,
        S_HOUR  = 8'b0000_1000,
        S_MIN   = 8'b0001_0000,
        S_YEAR  = 8'b0010_0000,
        S_MONTH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             ge;
    } t_alu_rsp;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

/* rtl/ecal_alu.sv */
// Shared compare-and-subtract unit of the calendar converter.
// Depends on ecal_pkg for the operand width and the response struct.
module ecal_alu (
    input  logic [ecal_pkg::ALU_W-1:0] i_a,
    input  logic [ecal_pkg::ALU_W-1:0] i_b,
    output ecal_pkg::t_alu_rsp         o_rsp
);
    import ecal_pkg::*;

    logic [ALU_W:0] w_full;

    assign w_full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_rsp.diff = w_full[ALU_W-1:0];
    assign o_rsp.ge   = ~w_full[ALU_W];

endmodule

/* rtl/epoch_seconds_to_calendar_core.sv */
// Top level of the epoch seconds to calendar converter.
// Depends on ecal_pkg and ecal_alu.
//
//  Channel   Dir  Signals                         Contents
//  -------   ---  ------------------------------  ---------------------------------
//  s         in   i_s_tvalid/o_s_tready/i_s_tdata  epoch seconds request
//  m         out  o_m_tvalid/i_m_tready/o_m_tdata  calendar date, time and weekday
//  cfg       in   i_cfg_we/i_cfg_wdata             zone offset in hours (signed)
//
// A request passes through a load step, the day split, the hour and minute
// splits, a year walk of one compare per year, a month walk of one compare
// per month and a hand-over step; the splits and walks share the single
// subtractor. Input is taken only while idle, so no new request is accepted
// until the last result has been handed to the output register.
// A result sits in the output register until taken; the next request may run
// meanwhile and holds in its last step while that register is full.
// Reset clears the sequencer, the output valid and the zone offset.
module epoch_seconds_to_calendar_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] epoch_seconds
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                     // [25:21] hour, [31:26] minute, [37:32] second,
                                     // [40:38] weekday, [47:41] zero
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata  // [4:0] zone_offset_hours
);
    import ecal_pkg::*;

    // Control registers
    t_state      r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [4:0]  r_zone;

    // Datapath registers
    logic [31:0] r_epoch, n_epoch;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_days, n_days;
    logic [3:0]  r_cnt, n_cnt;
    logic [2:0]  r_wmod, n_wmod;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_minute, n_minute;
    logic [11:0] r_year, n_year;
    logic [1:0]  r_mod4, n_mod4;
    logic [6:0]  r_mod100, n_mod100;
    logic [8:0]  r_mod400, n_mod400;
    logic [3:0]  r_month, n_month;
    logic [47:0] r_out_data, n_out_data;

    logic [31:0]        w_alu_a, w_alu_b;
    t_alu_rsp           w_alu;
    logic signed [17:0] w_zone_secs;
    logic signed [33:0] w_sum;
    logic               w_leap;
    logic [3:0]         w_wmod_x2;
    logic [2:0]         w_weekday;

    ecal_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_rsp (w_alu)
    );

    // Offset in seconds and the unclamped sum
    assign w_zone_secs = $signed(r_zone) * $signed(18'sd3600);
    assign w_sum       = $signed({2'b00, r_epoch}) + 34'(w_zone_secs);

    assign w_leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);

    // Day count mod 7 grows one quotient bit at a time
    assign w_wmod_x2 = {r_wmod, w_alu.ge};

    // Day zero was a Thursday; Monday is 1
    always_comb begin
        unique case (r_wmod)
            3'd0:    w_weekday = 3'd4;
            3'd1:    w_weekday = 3'd5;
            3'd2:    w_weekday = 3'd6;
            3'd3:    w_weekday = 3'd7;
            3'd4:    w_weekday = 3'd1;
            3'd5:    w_weekday = 3'd2;
            3'd6:    w_weekday = 3'd3;
            default: w_weekday = 3'd4;
        endcase
    end

    // Operand select for the shared subtractor
    always_comb begin
        w_alu_a = r_rem;
        w_alu_b = '0;
        unique case (r_state)
            S_DAYS:  w_alu_b = SECS_PER_DAY << r_cnt;
            S_HOUR:  w_alu_b = {15'd0, SECS_PER_HOUR << r_cnt};
            S_MIN:   w_alu_b = {20'd0, SECS_PER_MIN << r_cnt};
            S_YEAR: begin
                w_alu_a = {16'd0, r_days};
                w_alu_b = w_leap ? 32'd366 : 32'd365;
            end
            S_MONTH: begin
                w_alu_a = {16'd0, r_days};
                w_alu_b = {27'd0, month_len(r_month, w_leap)};
            end
            default: w_alu_b = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_epoch     = r_epoch;
        n_rem       = r_rem;
        n_days      = r_days;
        n_cnt       = r_cnt;
        n_wmod      = r_wmod;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_year      = r_year;
        n_mod4      = r_mod4;
        n_mod100    = r_mod100;
        n_mod400    = r_mod400;
        n_month     = r_month;
        n_out_data  = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_epoch = i_s_tdata;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // Clamp the shifted time to the unsigned 32-bit range
                priority if (w_sum[33]) begin
                    n_rem = '0;
                end else if (w_sum[32]) begin
                    n_rem = '1;
                end else begin
                    n_rem = w_sum[31:0];
                end
                n_cnt    = 4'd15;
                n_days   = '0;
                n_wmod   = '0;
                n_hour   = '0;
                n_minute = '0;
                n_state  = S_DAYS;
            end
            S_DAYS: begin
                if (w_alu.ge) begin
                    n_rem = w_alu.diff;
                end
                n_days = {r_days[14:0], w_alu.ge};
                n_wmod = (w_wmod_x2 >= 4'd7) ? 3'(w_wmod_x2 - 4'd7) : w_wmod_x2[2:0];
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_cnt   = 4'd4;
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (w_alu.ge) begin
                    n_rem = w_alu.diff;
                end
                n_hour = {r_hour[3:0], w_alu.ge};
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_cnt   = 4'd5;
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (w_alu.ge) begin
                    n_rem = w_alu.diff;
                end
                n_minute = {r_minute[4:0], w_alu.ge};
                n_cnt    = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_year   = FIRST_YEAR;
                    n_mod4   = FIRST_MOD4;
                    n_mod100 = FIRST_MOD100;
                    n_mod400 = FIRST_MOD400;
                    n_state  = S_YEAR;
                end
            end
            S_YEAR: begin
                // Drop one whole year per cycle
                if (w_alu.ge) begin
                    n_days   = w_alu.diff[15:0];
                    n_year   = r_year + 12'd1;
                    n_mod4   = r_mod4 + 2'd1;
                    n_mod100 = (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
                    n_mod400 = (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
                end else begin
                    n_month = '0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                // Drop one whole month per cycle; December takes what is left
                if ((r_month == LAST_MONTH) || !w_alu.ge) begin
                    n_state = S_DONE;
                end else begin
                    n_days  = w_alu.diff[15:0];
                    n_month = r_month + 4'd1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_data  = {7'd0, w_weekday, r_rem[5:0], r_minute, r_hour,
                                   5'(r_days + 16'd1), r_month + 4'd1, r_year};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_zone      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_zone <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_epoch    <= n_epoch;
        r_rem      <= n_rem;
        r_days     <= n_days;
        r_cnt      <= n_cnt;
        r_wmod     <= n_wmod;
        r_hour     <= n_hour;
        r_minute   <= n_minute;
        r_year     <= n_year;
        r_mod4     <= n_mod4;
        r_mod100   <= n_mod100;
        r_mod400   <= n_mod400;
        r_month    <= n_month;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
